### rtl/spmu_pkg.sv
package spmu_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANG_BITS         = 30;
  localparam int TRIG_BITS        = 26;
  localparam int TABLE_LEN        = 24;
  localparam int ZW               = 42;
  localparam int CW               = 32;
  localparam int MW               = 38;

  localparam logic [16:0] DECAY_RESET = 17'd62915;
  localparam logic signed [ZW-1:0] INV_GAIN = 42'sd652032874;
  localparam logic signed [ZW-1:0] PI_Q30 = 42'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 42'sd1686629713;
  localparam logic signed [MW-1:0] MID_LIMIT = 38'sd68719476735;

  typedef logic signed [31:0] s32_t;

  typedef struct packed {
    logic signed [ZW-1:0] cx;
    logic signed [ZW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cordic_t;

  typedef struct packed {
    logic signed [MW-1:0] px;
    logic signed [MW-1:0] py;
    logic signed [MW-1:0] vx;
    logic signed [MW-1:0] vy;
    s32_t                 dx;
    s32_t                 dy;
  } vec_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] t [TABLE_LEN];
    t = '{42'sh3243F6A8, 42'sh1DAC6705, 42'sh0FADBAFC, 42'sh07F56EA6, 42'sh03FEAB76,
          42'sh01FFD55B, 42'sh00FFFAAA, 42'sh007FFF55, 42'sh003FFFEA, 42'sh001FFFFD,
          42'sh000FFFFF, 42'sh0007FFFF, 42'sh0003FFFF, 42'sh0001FFFF, 42'sh0000FFFF,
          42'sh00007FFF, 42'sh00003FFF, 42'sh00001FFF, 42'sh00000FFF, 42'sh000007FF,
          42'sh000003FF, 42'sh000001FF, 42'sh000000FF, 42'sh0000007F};
    return t[i];
  endfunction

  function automatic logic signed [MW-1:0] clamp_mid(input logic signed [63:0] v);
    if (v > 64'(MID_LIMIT)) return MID_LIMIT;
    if (v < -64'(MID_LIMIT)) return -MID_LIMIT;
    return v[MW-1:0];
  endfunction

  function automatic s32_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

### rtl/spmu_cordic_cell.sv
module spmu_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  spmu_pkg::cordic_t c_in,
  input  spmu_pkg::vec_t    v_in,
  output spmu_pkg::cordic_t c_out,
  output spmu_pkg::vec_t    v_out
);
  import spmu_pkg::*;

  cordic_t c_nxt;
  cordic_t c_r;
  vec_t    v_r;

  always_comb begin
    c_nxt = c_in;
    if (c_in.z >= 0) begin
      c_nxt.cx = c_in.cx - (c_in.cy >>> STEP);
      c_nxt.cy = c_in.cy + (c_in.cx >>> STEP);
      c_nxt.z  = c_in.z - atan_q30(STEP);
    end else begin
      c_nxt.cx = c_in.cx + (c_in.cy >>> STEP);
      c_nxt.cy = c_in.cy - (c_in.cx >>> STEP);
      c_nxt.z  = c_in.z + atan_q30(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
      v_r <= v_in;
    end
  end

  assign c_out = c_r;
  assign v_out = v_r;
endmodule

### rtl/sigma_point_motion_update_core.sv
// An item is registered in stage 0, each CORDIC cell and stages NS+1 to NS+3.
// Throughput: one item per cycle; the pipeline of CORDIC cells advances whenever
// the output register is empty or being taken.
// Reset (rst_n low, synchronous) empties the pipeline and sets velocity_decay
// to 0.96 in Q1.16.
module sigma_point_motion_update_core #(
  parameter int FRAC_BITS    = spmu_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = spmu_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [16:0]        cfg_velocity_decay,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x_in,
  input  logic signed [31:0] in_pos_y_in,
  input  logic signed [31:0] in_vel_x_in,
  input  logic signed [31:0] in_vel_y_in,
  input  logic [19:0]        in_step_time,
  input  logic signed [31:0] in_odo_dx,
  input  logic signed [31:0] in_odo_dy,
  input  logic signed [18:0] in_odo_turn,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x_out,
  output logic signed [31:0] out_pos_y_out,
  output logic signed [31:0] out_vel_x_out,
  output logic signed [31:0] out_vel_y_out
);
  import spmu_pkg::*;

  localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int NV = NS + 4;
  localparam logic [16:0] DECAY_INIT = 17'(((96 << FRAC_BITS) + 50) / 100);

  logic [16:0] decay_r;
  logic [NV-1:0] vld_r;
  logic en;

  assign en        = !vld_r[NV-1] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_INIT;
      vld_r   <= '0;
    end else begin
      if (cfg_valid) decay_r <= cfg_velocity_decay;
      if (en) vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  // Stage 0: products and quadrant fold.
  logic signed [63:0] tvx_r, tvy_r, dvx_r, dvy_r;
  s32_t px0_r, py0_r, dx0_r, dy0_r;
  cordic_t c0_r;
  logic signed [ZW-1:0] z_in;
  cordic_t c0_nxt;

  always_comb begin
    z_in = ZW'($signed(in_odo_turn)) <<< (ANG_BITS - FRAC_BITS);
    c0_nxt.cx  = INV_GAIN;
    c0_nxt.cy  = '0;
    c0_nxt.z   = z_in;
    c0_nxt.neg = 1'b0;
    if (z_in > HALF_PI_Q30) begin
      c0_nxt.z = z_in - PI_Q30;
      c0_nxt.neg = 1'b1;
    end else if (z_in < -HALF_PI_Q30) begin
      c0_nxt.z = z_in + PI_Q30;
      c0_nxt.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tvx_r <= $signed({1'b0, in_step_time}) * 64'(in_vel_x_in);
      tvy_r <= $signed({1'b0, in_step_time}) * 64'(in_vel_y_in);
      dvx_r <= $signed({1'b0, decay_r}) * 64'(in_vel_x_in);
      dvy_r <= $signed({1'b0, decay_r}) * 64'(in_vel_y_in);
      px0_r <= in_pos_x_in;
      py0_r <= in_pos_y_in;
      dx0_r <= in_odo_dx;
      dy0_r <= in_odo_dy;
      c0_r  <= c0_nxt;
    end
  end

  // Stage 1: rounding and intermediate clamp.
  localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);
  vec_t v1;
  always_comb begin
    v1.px = clamp_mid(64'(px0_r) + ((tvx_r + HALF_F) >>> FRAC_BITS));
    v1.py = clamp_mid(64'(py0_r) + ((tvy_r + HALF_F) >>> FRAC_BITS));
    v1.vx = clamp_mid((dvx_r + HALF_F) >>> FRAC_BITS);
    v1.vy = clamp_mid((dvy_r + HALF_F) >>> FRAC_BITS);
    v1.dx = dx0_r;
    v1.dy = dy0_r;
  end

  cordic_t c_ch [NS+1];
  vec_t    v_ch [NS+1];
  assign c_ch[0] = c0_r;
  assign v_ch[0] = v1;

  for (genvar g = 0; g < NS; g++) begin : g_cell
    spmu_cordic_cell #(.STEP(g)) u_cell (
      .clk(clk), .en(en), .c_in(c_ch[g]), .v_in(v_ch[g]),
      .c_out(c_ch[g+1]), .v_out(v_ch[g+1])
    );
  end

  // Stage NS+1: sign fix and rounding to Q26.
  localparam logic signed [ZW-1:0] HALF_T = ZW'(1) <<< (ANG_BITS - TRIG_BITS - 1);
  logic signed [ZW-1:0] cf, sf;
  logic signed [CW-1:0] cos_r, sin_r;
  vec_t v2_r;
  always_comb begin
    cf = c_ch[NS].neg ? -c_ch[NS].cx : c_ch[NS].cx;
    sf = c_ch[NS].neg ? -c_ch[NS].cy : c_ch[NS].cy;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= CW'((cf + HALF_T) >>> (ANG_BITS - TRIG_BITS));
      sin_r <= CW'((sf + HALF_T) >>> (ANG_BITS - TRIG_BITS));
      v2_r  <= v_ch[NS];
    end
  end

  // Stage NS+2: eight products.
  logic signed [71:0] pxc_r, pys_r, pyc_r, pxs_r, vxc_r, vys_r, vyc_r, vxs_r;
  s32_t dx3_r, dy3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pxc_r <= 72'(v2_r.px) * 72'(cos_r);
      pys_r <= 72'(v2_r.py) * 72'(sin_r);
      pyc_r <= 72'(v2_r.py) * 72'(cos_r);
      pxs_r <= 72'(v2_r.px) * 72'(sin_r);
      vxc_r <= 72'(v2_r.vx) * 72'(cos_r);
      vys_r <= 72'(v2_r.vy) * 72'(sin_r);
      vyc_r <= 72'(v2_r.vy) * 72'(cos_r);
      vxs_r <= 72'(v2_r.vx) * 72'(sin_r);
      dx3_r <= v2_r.dx;
      dy3_r <= v2_r.dy;
    end
  end

  // Stage NS+3: sums, rounding, translation and saturation.
  localparam logic signed [71:0] HALF_R = 72'sd1 <<< (TRIG_BITS - 1);
  logic signed [71:0] rx, ry, wx, wy;
  always_comb begin
    rx = ((pxc_r + pys_r + HALF_R) >>> TRIG_BITS) - 72'(dx3_r);
    ry = ((pyc_r - pxs_r + HALF_R) >>> TRIG_BITS) - 72'(dy3_r);
    wx = (vxc_r + vys_r + HALF_R) >>> TRIG_BITS;
    wy = (vyc_r - vxs_r + HALF_R) >>> TRIG_BITS;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_x_out <= sat32(rx[63:0]);
      out_pos_y_out <= sat32(ry[63:0]);
      out_vel_x_out <= sat32(wx[63:0]);
      out_vel_y_out <= sat32(wy[63:0]);
    end
  end

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result item dropped");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("ready low with empty output");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0]) else $error("accepted item lost");
`endif
endmodule

### tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NSTEPS       = 16;
  localparam int  LATENCY      = NSTEPS + 4;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  LONG_HOLD    = 400;
  localparam longint INV_GAIN  = 64'sd652032874;
  localparam longint PI_Z      = 64'sd3373259426;
  localparam longint HALF_PI_Z = 64'sd1686629713;
  localparam longint MID_MAX   = (64'sd1 <<< 36) - 1;
  localparam longint ATAN_Z [16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

  typedef struct {
    logic signed [31:0] px, py, vx, vy;
    logic        [19:0] dt;
    logic signed [31:0] dx, dy;
    logic signed [18:0] turn;
  } motion_item_t;

  typedef struct {
    logic signed [31:0] px, py, vx, vy;
  } track_state_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [16:0]        cfg_velocity_decay = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_pos_x_in = '0, in_pos_y_in = '0, in_vel_x_in = '0, in_vel_y_in = '0;
  logic [19:0]        in_step_time = '0;
  logic signed [31:0] in_odo_dx = '0, in_odo_dy = '0;
  logic signed [18:0] in_odo_turn = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_pos_x_out, out_pos_y_out, out_vel_x_out, out_vel_y_out;

  motion_item_t pending_items [$];
  track_state_t expected_states [$];
  motion_item_t offered;
  logic [16:0]  decay_shadow = spmu_pkg::DECAY_RESET;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_request = 0;
  int           hold_left = 0;
  int           mismatches = 0;
  int           cycles = 0;

  sigma_point_motion_update_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_velocity_decay(cfg_velocity_decay),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pos_x_in(in_pos_x_in), .in_pos_y_in(in_pos_y_in),
    .in_vel_x_in(in_vel_x_in), .in_vel_y_in(in_vel_y_in),
    .in_step_time(in_step_time), .in_odo_dx(in_odo_dx), .in_odo_dy(in_odo_dy),
    .in_odo_turn(in_odo_turn),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x_out(out_pos_x_out), .out_pos_y_out(out_pos_y_out),
    .out_vel_x_out(out_vel_x_out), .out_vel_y_out(out_vel_y_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint rnd(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    longint c;
    c = clip(v, -64'sd2147483648, 64'sd2147483647);
    return c[31:0];
  endfunction

  function automatic track_state_t propagate(input motion_item_t it, input logic [16:0] decay);
    longint px, py, vx, vy, t, dec, z, x, y, nx, c, s;
    bit flip;
    track_state_t r;
    px = it.px; py = it.py; vx = it.vx; vy = it.vy;
    t = it.dt; dec = decay; z = it.turn;
    px = clip(px + rnd(t * vx, 16), -MID_MAX, MID_MAX);
    py = clip(py + rnd(t * vy, 16), -MID_MAX, MID_MAX);
    vx = clip(rnd(vx * dec, 16), -MID_MAX, MID_MAX);
    vy = clip(rnd(vy * dec, 16), -MID_MAX, MID_MAX);
    z = z * 16384;
    flip = 0;
    if (z > HALF_PI_Z) begin
      z -= PI_Z; flip = 1;
    end else if (z < -HALF_PI_Z) begin
      z += PI_Z; flip = 1;
    end
    x = INV_GAIN; y = 0;
    for (int i = 0; i < NSTEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_Z[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_Z[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = rnd(x, 4);
    s = rnd(y, 4);
    r.px = sat32(rnd(px * c + py * s, 26) - longint'(it.dx));
    r.py = sat32(rnd(py * c - px * s, 26) - longint'(it.dy));
    r.vx = sat32(rnd(vx * c + vy * s, 26));
    r.vy = sat32(rnd(vy * c - vx * s, 26));
    return r;
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      2: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
      default: return $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(3)
                                        : 32'sh8000_0000 + $urandom_range(3);
    endcase
  endfunction

  function automatic motion_item_t rand_item();
    motion_item_t it;
    it.px = rand_word(); it.py = rand_word();
    it.vx = rand_word(); it.vy = rand_word();
    it.dx = rand_word(); it.dy = rand_word();
    it.dt = $urandom_range(1) ? 20'($urandom) : 20'($urandom_range(0, 16384));
    case ($urandom_range(7))
      0: it.turn = 19'($urandom);
      1: it.turn = $urandom_range(1) ? 19'sd102944 : -19'sd102944;
      default: it.turn = 19'($urandom_range(0, 411774)) - 19'sd205887;
    endcase
    return it;
  endfunction

  function automatic motion_item_t make_item(input logic signed [31:0] p, v, d,
                                              input logic [19:0] dt,
                                              input logic signed [18:0] turn);
    motion_item_t it;
    it.px = p; it.py = -p; it.vx = v; it.vy = ~v;
    it.dx = d; it.dy = ~d; it.dt = dt; it.turn = turn;
    return it;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_ready)
      expected_states.push_back(propagate(offered, decay_shadow));
    if (!in_valid || in_ready) begin
      if (rst_n && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_items.pop_front();
        in_pos_x_in  <= offered.px;
        in_pos_y_in  <= offered.py;
        in_vel_x_in  <= offered.vx;
        in_vel_y_in  <= offered.vy;
        in_step_time <= offered.dt;
        in_odo_dx    <= offered.dx;
        in_odo_dy    <= offered.dy;
        in_odo_turn  <= offered.turn;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    track_state_t want;
    if (out_valid && out_ready) begin
      if (expected_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: %0d %0d %0d %0d",
                   out_pos_x_out, out_pos_y_out, out_vel_x_out, out_vel_y_out);
      end else begin
        want = expected_states.pop_front();
        if (want.px !== out_pos_x_out || want.py !== out_pos_y_out ||
            want.vx !== out_vel_x_out || want.vy !== out_vel_y_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     want.px, want.py, want.vx, want.vy,
                     out_pos_x_out, out_pos_y_out, out_vel_x_out, out_vel_y_out);
        end
      end
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_states.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_decay(input logic [16:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_velocity_decay <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    decay_shadow = value;
  endtask

  task automatic run_phase(input int n, input int idle, input int stall, input bit hold);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) pending_items.push_back(rand_item());
    if (hold) begin
      repeat (4) @(posedge clk);
      hold_request = 1;
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    pending_items.push_back(make_item(0, 0, 0, 0, 0));
    pending_items.push_back(make_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 20'hFFFFF, 0));
    pending_items.push_back(make_item(32'sh80000000, 32'sh80000000, 0, 20'hFFFFF, 0));
    pending_items.push_back(make_item(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      20'hFFFFF, 19'sd205887));
    pending_items.push_back(make_item(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                                      20'hFFFFF, -19'sd205887));
    pending_items.push_back(make_item(32'sh00010000, 32'sh00020000, 0, 20'h10000,
                                      19'sd102944));
    pending_items.push_back(make_item(32'sh00010000, 32'sh00020000, 0, 20'h10000,
                                      19'sd102943));
    pending_items.push_back(make_item(32'sh00010000, 32'sh00020000, 0, 20'h10000,
                                      -19'sd102944));
    pending_items.push_back(make_item(32'sh00010000, 32'sh00020000, 0, 20'h10000,
                                      -19'sd102943));
    pending_items.push_back(make_item(32'sh00050000, -32'sh00030000, 32'sh7FFFFFFF,
                                      20'h00001, 19'sh3FFFF));
    pending_items.push_back(make_item(-32'sh00050000, 32'sh00030000, 32'sh80000000,
                                      20'h00001, 19'sh40000));
    pending_items.push_back(make_item(32'sh12345678, -32'sh00001234, 32'sh00001000,
                                      20'h08000, 19'sd51472));
    pending_items.push_back(make_item(-1, -1, -1, 20'hFFFFF, -1));
    pending_items.push_back(make_item(32'sh55555555, 32'shAAAAAAAA, 32'sh5A5A5A5A,
                                      20'h55555, 19'sh2AAAA));
    pending_items.push_back(make_item(32'shAAAAAAAA, 32'sh55555555, 32'shA5A5A5A5,
                                      20'hAAAAA, 19'sh15555));
    run_phase(0, 0, 0, 0);
    write_decay(17'd65536);
    pending_items.push_back(make_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 19'sd205887));
    pending_items.push_back(make_item(32'sh80000000, 32'sh80000000, 0, 0, 0));
    run_phase(100, 80, 0, 0);
    write_decay(17'd0);
    run_phase(100, 0, 80, 1);
    write_decay(17'($urandom_range(1, 65535)));
    run_phase(100, 26, 26, 0);
    write_decay(17'($urandom_range(0, 65536)));
    run_phase(150, 0, 0, 1);
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
